>>> hdl/box_mean_filter_clipped_core_macros.svh
// Assertion macros used by the checker file.
`ifndef BOX_MEAN_FILTER_CLIPPED_CORE_MACROS_SVH
`define BOX_MEAN_FILTER_CLIPPED_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk and switched off during reset.
`define BMF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and switched off during reset.
`define BMF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/bmf_pkg.sv
package bmf_pkg;

  localparam int DEF_MAX_WIDTH       = 1024;
  localparam int DEF_MAX_HALF_KERNEL = 15;
  localparam int DEF_PIXEL_BITS      = 16;
  localparam int MAX_HEIGHT          = 1024;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH   = 2'd0,
    REG_IMAGE_HEIGHT  = 2'd1,
    REG_HALF_KERNEL_X = 2'd2,
    REG_HALF_KERNEL_Y = 2'd3
  } reg_idx_t;

  localparam logic [10:0] RST_IMAGE_WIDTH   = 11'd640;
  localparam logic [10:0] RST_IMAGE_HEIGHT  = 11'd480;
  localparam logic [3:0]  RST_HALF_KERNEL_X = 4'd3;
  localparam logic [4:0]  RST_HALF_KERNEL_Y = 5'h1F;

endpackage

>>> hdl/box_mean_filter_clipped_core.sv
// An item that releases a result starts its window: the store rows are read and summed,
// the sum is divided by the pixel count, and the mean is registered at the output.
// Items that release no result are taken back to back; one that does holds the input until
// its mean is loaded, longer while the previous result still waits at the output, a pace set
// by the single read port of the row store and the bit-serial divider.
// Reset is synchronous, active low: counters clear, registers take their defaults, and the
// input is not ready in the cycle after reset or after any register write. The row store is not cleared.
module box_mean_filter_clipped_core #(
  parameter int MAX_WIDTH       = bmf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HALF_KERNEL = bmf_pkg::DEF_MAX_HALF_KERNEL,
  parameter int PIXEL_BITS      = bmf_pkg::DEF_PIXEL_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // tdata: pixel
  input  logic [((PIXEL_BITS+7)/8)*8-1:0]  in_tdata,
  // tuser: is_pad
  input  logic                             in_tuser,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // tdata: mean_value
  output logic [((PIXEL_BITS+7)/8)*8-1:0]  out_tdata,
  output logic                             out_tlast,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic                             cfg_we,
  input  logic [bmf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bmf_pkg::CFG_DATA_W-1:0]   cfg_data
);

  import bmf_pkg::*;

  localparam int DATA_W     = ((PIXEL_BITS + 7) / 8) * 8;
  localparam int KE         = (MAX_HALF_KERNEL < 15) ? MAX_HALF_KERNEL : 15;
  localparam int STORE_ROWS = 2 * MAX_HALF_KERNEL + 2;
  localparam int SLOT_W     = $clog2(STORE_ROWS);
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int W_W        = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int H_W        = $clog2(MAX_HEIGHT + 1);
  localparam int POS_W      = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int K_W        = 4;
  localparam int WIN        = 2 * KE + 1;
  localparam int SPAN_W     = $clog2(WIN);
  localparam int CNT_W      = $clog2(WIN * WIN + 1);
  localparam int SUM_W      = PIXEL_BITS + $clog2(WIN * WIN);
  localparam int AW         = $clog2(STORE_ROWS * MAX_WIDTH);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SETUP = 5'b00010,
    S_SUM   = 5'b00100,
    S_DIV   = 5'b01000,
    S_PUT   = 5'b10000
  } state_t;

  state_t state_r;

  logic [10:0] width_r;
  logic [10:0] height_r;
  logic [3:0]  hkx_r;
  logic [4:0]  hky_r;
  logic        settle_r;

  logic [W_W-1:0]   weff_r,  weff_nxt;
  logic [H_W-1:0]   heff_r,  heff_nxt;
  logic [K_W-1:0]   kx_r,    kx_nxt;
  logic [K_W-1:0]   ky_r,    ky_nxt;
  logic [POS_W-1:0] total_r, total_nxt;
  logic [POS_W-1:0] lag_r,   lag_nxt;

  logic [POS_W-1:0]  ip_r;
  logic [POS_W-1:0]  op_r;
  logic [COL_W-1:0]  in_col_r;
  logic [SLOT_W-1:0] in_slot_r;
  logic [ROW_W-1:0]  out_row_r;
  logic [COL_W-1:0]  out_col_r;
  logic [SLOT_W-1:0] out_slot_r;

  logic [ROW_W-1:0]  wrk_row_r;
  logic [COL_W-1:0]  wrk_col_r;
  logic [SLOT_W-1:0] wrk_slot_r;
  logic              wrk_last_r;

  logic [COL_W-1:0]  c0_r, c1_r;
  logic [COL_W-1:0]  rd_col_r;
  logic [SLOT_W-1:0] rd_slot_r;
  logic [SPAN_W-1:0] rows_left_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [SUM_W-1:0]  acc_r;
  logic              issuing_r;
  logic              rd_pend_r;

  logic              out_valid_r;
  logic [PIXEL_BITS-1:0] out_data_r;
  logic              out_last_r;

  logic [COL_W-1:0]  c0_nxt, c1_nxt;
  logic [SLOT_W-1:0] slot0_nxt;
  logic [SPAN_W-1:0] rows_nxt;
  logic [CNT_W-1:0]  cnt_nxt;

  logic                  accept;
  logic                  filling;
  logic                  wr_en;
  logic                  have_res;
  logic                  last_out;
  logic [AW-1:0]         wr_addr;
  logic [AW-1:0]         rd_addr;
  logic                  rd_en;
  logic [PIXEL_BITS-1:0] rd_data;
  logic                  div_start;
  logic                  div_done;
  logic [PIXEL_BITS-1:0] quotient;
  logic                  load_out;

  // Effective geometry, registered once so that the item path sees settled values.
  always_comb begin
    int wi, hi, kxi, kyi;
    wi = int'(width_r);
    if (wi < 1) wi = 1;
    if (wi > MAX_WIDTH) wi = MAX_WIDTH;
    hi = int'(height_r);
    if (hi < 1) hi = 1;
    if (hi > MAX_HEIGHT) hi = MAX_HEIGHT;
    kxi = int'(hkx_r);
    if (kxi > wi - 1) kxi = wi - 1;
    if (kxi > KE) kxi = KE;
    kyi = hky_r[4] ? int'(hkx_r) : int'(hky_r[3:0]);
    if (kyi > hi - 1) kyi = hi - 1;
    if (kyi > KE) kyi = KE;
    weff_nxt  = W_W'(wi);
    heff_nxt  = H_W'(hi);
    kx_nxt    = K_W'(kxi);
    ky_nxt    = K_W'(kyi);
    total_nxt = POS_W'(wi * hi);
    lag_nxt   = POS_W'(kyi * wi + kxi);
  end

  always_ff @(posedge clk) begin
    weff_r  <= weff_nxt;
    heff_r  <= heff_nxt;
    kx_r    <= kx_nxt;
    ky_r    <= ky_nxt;
    total_r <= total_nxt;
    lag_r   <= lag_nxt;
  end

  assign in_tready = (state_r == S_IDLE) && !settle_r;
  assign accept    = in_tvalid && in_tready;
  assign filling   = (ip_r < total_r);
  assign wr_en     = accept && filling && !in_tuser;
  assign last_out  = (op_r == total_r - 1'b1);

  // Once the frame is complete every item releases a result; before that a pixel releases
  // the result whose window it completes.
  assign have_res = accept && (!filling ||
                    (!in_tuser && ({1'b0, op_r} + {1'b0, lag_r}) < ({1'b0, ip_r} + 1'b1)));

  assign wr_addr = AW'(int'(in_slot_r) * MAX_WIDTH + int'(in_col_r));
  assign rd_addr = AW'(int'(rd_slot_r) * MAX_WIDTH + int'(rd_col_r));
  assign rd_en   = (state_r == S_SUM) && issuing_r;

  // Window bounds clipped to the image, and the store row that holds the top row.
  always_comb begin
    int ri, ci, kx, ky, r0, r1, q0, q1, d, s;
    ri = int'(wrk_row_r);
    ci = int'(wrk_col_r);
    kx = int'(kx_r);
    ky = int'(ky_r);
    r0 = (ri > ky) ? ri - ky : 0;
    r1 = (ri + ky > int'(heff_r) - 1) ? int'(heff_r) - 1 : ri + ky;
    q0 = (ci > kx) ? ci - kx : 0;
    q1 = (ci + kx > int'(weff_r) - 1) ? int'(weff_r) - 1 : ci + kx;
    d  = ri - r0;
    s  = (int'(wrk_slot_r) >= d) ? int'(wrk_slot_r) - d : int'(wrk_slot_r) + STORE_ROWS - d;
    c0_nxt    = COL_W'(q0);
    c1_nxt    = COL_W'(q1);
    slot0_nxt = SLOT_W'(s);
    rows_nxt  = SPAN_W'(r1 - r0);
    cnt_nxt   = CNT_W'((r1 - r0 + 1) * (q1 - q0 + 1));
  end

  assign div_start = (state_r == S_SUM) && !issuing_r && !rd_pend_r;
  assign load_out  = (state_r == S_PUT) && !cfg_we && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      settle_r    <= 1'b1;
      width_r     <= RST_IMAGE_WIDTH;
      height_r    <= RST_IMAGE_HEIGHT;
      hkx_r       <= RST_HALF_KERNEL_X;
      hky_r       <= RST_HALF_KERNEL_Y;
      ip_r        <= '0;
      op_r        <= '0;
      in_col_r    <= '0;
      in_slot_r   <= '0;
      out_row_r   <= '0;
      out_col_r   <= '0;
      out_slot_r  <= '0;
      issuing_r   <= 1'b0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready && !load_out) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_IMAGE_WIDTH:   width_r  <= cfg_data[10:0];
          REG_IMAGE_HEIGHT:  height_r <= cfg_data[10:0];
          REG_HALF_KERNEL_X: hkx_r    <= cfg_data[3:0];
          REG_HALF_KERNEL_Y: hky_r    <= cfg_data[4:0];
          default: ;
        endcase
        settle_r   <= 1'b1;
        state_r    <= S_IDLE;
        ip_r       <= '0;
        op_r       <= '0;
        in_col_r   <= '0;
        in_slot_r  <= '0;
        out_row_r  <= '0;
        out_col_r  <= '0;
        out_slot_r <= '0;
      end else begin
        settle_r <= 1'b0;
        case (state_r)
          S_IDLE: begin
            if (have_res && last_out) begin
              // Frame finished: both sides start over.
              state_r    <= S_SETUP;
              ip_r       <= '0;
              op_r       <= '0;
              in_col_r   <= '0;
              in_slot_r  <= '0;
              out_row_r  <= '0;
              out_col_r  <= '0;
              out_slot_r <= '0;
            end else begin
              if (wr_en) begin
                ip_r <= ip_r + 1'b1;
                if (W_W'(in_col_r) + 1'b1 == weff_r) begin
                  in_col_r  <= '0;
                  in_slot_r <= (in_slot_r == SLOT_W'(STORE_ROWS - 1)) ? '0 : in_slot_r + 1'b1;
                end else begin
                  in_col_r <= in_col_r + 1'b1;
                end
              end
              if (have_res) begin
                state_r <= S_SETUP;
                op_r    <= op_r + 1'b1;
                if (W_W'(out_col_r) + 1'b1 == weff_r) begin
                  out_col_r  <= '0;
                  out_row_r  <= out_row_r + 1'b1;
                  out_slot_r <= (out_slot_r == SLOT_W'(STORE_ROWS - 1)) ? '0 : out_slot_r + 1'b1;
                end else begin
                  out_col_r <= out_col_r + 1'b1;
                end
              end
            end
          end
          S_SETUP: begin
            issuing_r <= 1'b1;
            rd_pend_r <= 1'b0;
            state_r   <= S_SUM;
          end
          S_SUM: begin
            rd_pend_r <= issuing_r;
            if (issuing_r && (rd_col_r == c1_r) && (rows_left_r == '0)) begin
              issuing_r <= 1'b0;
            end
            if (div_start) begin
              state_r <= S_DIV;
            end
          end
          S_DIV: begin
            if (div_done) begin
              state_r <= S_PUT;
            end
          end
          S_PUT: begin
            if (load_out) begin
              out_valid_r <= 1'b1;
              state_r     <= S_IDLE;
            end
          end
          default: state_r <= S_IDLE;
        endcase
      end
    end
  end

  // Window walk: one store read per cycle, row by row.
  always_ff @(posedge clk) begin
    if (have_res) begin
      wrk_row_r  <= out_row_r;
      wrk_col_r  <= out_col_r;
      wrk_slot_r <= out_slot_r;
      wrk_last_r <= last_out;
    end
    if (state_r == S_SETUP) begin
      c0_r        <= c0_nxt;
      c1_r        <= c1_nxt;
      rd_col_r    <= c0_nxt;
      rd_slot_r   <= slot0_nxt;
      rows_left_r <= rows_nxt;
      cnt_r       <= cnt_nxt;
      acc_r       <= '0;
    end else if (state_r == S_SUM) begin
      if (issuing_r) begin
        if (rd_col_r == c1_r) begin
          rd_col_r <= c0_r;
          if (rows_left_r != '0) begin
            rows_left_r <= rows_left_r - 1'b1;
            rd_slot_r   <= (rd_slot_r == SLOT_W'(STORE_ROWS - 1)) ? '0 : rd_slot_r + 1'b1;
          end
        end else begin
          rd_col_r <= rd_col_r + 1'b1;
        end
      end
      if (rd_pend_r) begin
        acc_r <= acc_r + SUM_W'(rd_data);
      end
    end
    if (load_out) begin
      out_data_r <= quotient;
      out_last_r <= wrk_last_r;
    end
  end

  bmf_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (STORE_ROWS * MAX_WIDTH)
  ) u_row_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_tdata[PIXEL_BITS-1:0]),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  bmf_div #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W),
    .QUO_W (PIXEL_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (acc_r),
    .divisor  (cnt_r),
    .quotient (quotient),
    .done     (div_done)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = DATA_W'(out_data_r);
  assign out_tlast  = out_last_r;

endmodule

>>> hdl/bmf_ram.sv
module bmf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hdl/bmf_div.sv
module bmf_div #(
  parameter int SUM_W   = 26,
  parameter int CNT_W   = 10,
  parameter int QUO_W   = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic [QUO_W-1:0] quotient,
  output logic             done
);

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [CNT_W-1:0]  rem_r;
  logic [SUM_W-1:0]  quo_r;
  logic [CNT_W-1:0]  dvs_r;

  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    diff;
  logic              ge;
  logic [CNT_W-1:0]  rem_nxt;

  // One quotient bit per cycle, restoring form.
  always_comb begin
    trial   = {rem_r, quo_r[SUM_W-1]};
    diff    = trial - {1'b0, dvs_r};
    ge      = (trial >= {1'b0, dvs_r});
    rem_nxt = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(SUM_W);
      end else if (busy_r) begin
        step_r <= step_r - 1'b1;
        if (step_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[SUM_W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  // The mean never exceeds the largest pixel, so the low bits hold it all.
  assign quotient = quo_r[QUO_W-1:0];
  assign done     = done_r;

endmodule

>>> hdl/bmf_checker.sv
`include "box_mean_filter_clipped_core_macros.svh"

module bmf_checker #(
  parameter int DATA_W = 16
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_tready,
  input logic [DATA_W-1:0] out_tdata,
  input logic              out_tlast,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic              cfg_we
);

  // A waiting item must not change or vanish.
  `BMF_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast), "output item changed while stalled")

  // After a register write the input is not ready in the next cycle, so new geometry settles before any item is taken.
  `BMF_ASSERT_NXT(a_cfg_settle, cfg_we, !in_tready, "input ready straight after a register write")

  // A result is loaded only from the output stage, never on the input cycle.
  `BMF_ASSERT_IMP(a_load_quiet, $rose(out_tvalid), !$past(in_tready), "result loaded while input was ready")

endmodule

bind box_mean_filter_clipped_core bmf_checker #(.DATA_W(DATA_W)) u_bmf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .cfg_we     (cfg_we)
);
